// ===== hdl/baro_pressure_temp_compensation_assert.svh =====
// Assertion macros shared by the compensation block.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// Check a consequence in the same cycle.
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bpc_pkg.sv =====
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int RAW_W         = 24;
    localparam int ACC_W         = 64;
    // quotient bits resolved per divider stage
    localparam int DIV_STEP      = 8;
    localparam int ODD_W         = 8;

    // scale factor k = SCALE_ODD[i] * 2^shift, shift high for the first four entries
    localparam logic [ODD_W-1:0] SCALE_ODD [8] = '{
        8'd1, 8'd3, 8'd7, 8'd15, 8'd31, 8'd63, 8'd127, 8'd255
    };
    localparam int SCALE_SHIFT_HI = 19;
    localparam int SCALE_SHIFT_LO = 13;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    clip;
    } sat_val_t;

    typedef enum logic [2:0] {
        CFG_C0_C1     = 3'd0,
        CFG_C00_C10   = 3'd1,
        CFG_C01_C11   = 3'd2,
        CFG_C20_C21   = 3'd3,
        CFG_C30       = 3'd4,
        CFG_TEMP_RATE = 3'd5,
        CFG_PRES_RATE = 3'd6
    } cfg_reg_t;

    // number of divider stages for a given fraction width
    function automatic int scale_stages(input int frac);
        return (frac + 11 + DIV_STEP - 1) / DIV_STEP;
    endfunction

    // signed add that clips at the accumulator range
    function automatic sat_val_t sat_add64(input logic signed [ACC_W-1:0] a,
                                           input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        sat_val_t              r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            r.clip  = 1'b1;
            r.value = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            r.clip  = 1'b0;
            r.value = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/bpc_scale.sv =====
`timescale 1ns / 1ps

module bpc_scale
    import bpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic [RAW_W-1:0]                  raw,
    input  logic [2:0]                        idx,
    output logic signed [FRAC_BITS+7:0]       scaled
);

    localparam int TW   = FRAC_BITS + 8;
    localparam int NSTG = scale_stages(FRAC_BITS);
    localparam int PW   = NSTG * DIV_STEP;

    logic [PW-1:0]    dvd_reg  [NSTG];
    logic [PW-1:0]    dvd_next [NSTG];
    logic [ODD_W-1:0] rem_reg  [NSTG];
    logic [ODD_W-1:0] rem_next [NSTG];
    logic [ODD_W-1:0] d_reg    [NSTG];
    logic [ODD_W-1:0] d_next   [NSTG];
    logic             neg_reg  [NSTG];
    logic             neg_next [NSTG];

    logic [RAW_W-1:0] mag0;
    logic [PW-1:0]    dvd0;
    logic             rnd;
    logic [TW-1:0]    qm;
    logic signed [TW-1:0] scaled_reg;
    logic signed [TW-1:0] scaled_next;

    // take the magnitude and line it up as the dividend for division by k = odd * 2^shift
    always_comb
    begin
        mag0 = raw[RAW_W-1] ? (~raw + 1'b1) : raw;
        if (idx[2])
            dvd0 = PW'(mag0) << (FRAC_BITS - SCALE_SHIFT_LO);
        else
            dvd0 = PW'(mag0) << (FRAC_BITS - SCALE_SHIFT_HI);
    end

    // advance the restoring division by DIV_STEP quotient bits per stage
    always_comb
    begin
        logic [PW-1:0]    dv;
        logic [ODD_W-1:0] rm;
        logic [ODD_W-1:0] dd;
        logic             ng;
        logic [ODD_W:0]   x;
        logic             qb;
        for (int s = 0; s < NSTG; s++)
        begin
            if (s == 0)
            begin
                dv = dvd0;
                rm = '0;
                dd = SCALE_ODD[idx];
                ng = raw[RAW_W-1];
            end
            else
            begin
                dv = dvd_reg[s-1];
                rm = rem_reg[s-1];
                dd = d_reg[s-1];
                ng = neg_reg[s-1];
            end
            for (int b = 0; b < DIV_STEP; b++)
            begin
                x = {rm, dv[PW-1]};
                if (x >= {1'b0, dd})
                begin
                    x  = x - {1'b0, dd};
                    qb = 1'b1;
                end
                else
                begin
                    qb = 1'b0;
                end
                rm = x[ODD_W-1:0];
                dv = {dv[PW-2:0], qb};
            end
            dvd_next[s] = dv;
            rem_next[s] = rm;
            d_next[s]   = dd;
            neg_next[s] = ng;
        end
    end

    // round half away from zero and restore the sign
    always_comb
    begin
        rnd         = {rem_reg[NSTG-1], 1'b0} > {1'b0, d_reg[NSTG-1]};
        qm          = dvd_reg[NSTG-1][TW-1:0] + TW'(rnd);
        scaled_next = neg_reg[NSTG-1] ? -$signed(qm) : $signed(qm);
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        d_reg      <= d_next;
        neg_reg    <= neg_next;
        scaled_reg <= scaled_next;
    end

    assign scaled = scaled_reg;

endmodule

// ===== hdl/bpc_mulq.sv =====
`timescale 1ns / 1ps

module bpc_mulq
    import bpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic signed [ACC_W-1:0] a,
    input  logic signed [ACC_W-1:0] b,
    output sat_val_t                res
);

    logic [ACC_W-1:0] ma;
    logic [ACC_W-1:0] mb;
    logic [63:0]      p00_reg, p01_reg, p10_reg, p11_reg;
    logic [63:0]      p00_next, p01_next, p10_next, p11_next;
    logic             neg_reg;
    logic             neg_next;
    logic [127:0]     prod;
    logic [63:0]      m;
    logic             over;
    sat_val_t         res_reg;
    sat_val_t         res_next;

    // split the magnitudes into 32-bit halves and form the partial products
    always_comb
    begin
        ma       = a[ACC_W-1] ? (64'd0 - a) : a;
        mb       = b[ACC_W-1] ? (64'd0 - b) : b;
        neg_next = a[ACC_W-1] ^ b[ACC_W-1];
        p00_next = ma[31:0]  * mb[31:0];
        p01_next = ma[31:0]  * mb[63:32];
        p10_next = ma[63:32] * mb[31:0];
        p11_next = ma[63:32] * mb[63:32];
    end

    // sum, round, drop the fraction and saturate
    always_comb
    begin
        prod = {64'd0, p00_reg}
             + {32'd0, p01_reg, 32'd0}
             + {32'd0, p10_reg, 32'd0}
             + {p11_reg, 64'd0}
             + (128'd1 << (FRAC_BITS - 1));
        over = |prod[127:64+FRAC_BITS];
        m    = prod[FRAC_BITS+63:FRAC_BITS];
        if (over)
        begin
            res_next.clip  = 1'b1;
            res_next.value = neg_reg ? ACC_MIN : ACC_MAX;
        end
        else if (!neg_reg)
        begin
            res_next.clip  = m[63];
            res_next.value = m[63] ? ACC_MAX : $signed(m);
        end
        else if (m[63])
        begin
            res_next.clip  = |m[62:0];
            res_next.value = ACC_MIN;
        end
        else
        begin
            res_next.clip  = 1'b0;
            res_next.value = -$signed(m);
        end
    end

    always_ff @(posedge clk)
    begin
        p00_reg <= p00_next;
        p01_reg <= p01_next;
        p10_reg <= p10_next;
        p11_reg <= p11_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== hdl/baro_pressure_temp_compensation.sv =====
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// request   start / busy         temp_raw, pressure_raw
// result    done (strobe)        temperature_q8, pressure_q8, saturated
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request per cycle; busy is always low. Each result follows its request down the pipeline:
// the scale divider takes eight quotient bits per stage, then registered multipliers chain
// through the pressure polynomial.
// Reset clears the valid line and loads the default calibration and rate indexes.
// The receiver cannot stall, so results are never held back.
`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation
    import bpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [RAW_W-1:0]    temp_raw,
    input  logic [RAW_W-1:0]    pressure_raw,
    output logic                done,
    output logic signed [15:0]  temperature_q8,
    output logic signed [31:0]  pressure_q8,
    output logic                saturated,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [39:0]         cfg_data
);

    localparam int TW   = FRAC_BITS + 8;
    localparam int NSTG = scale_stages(FRAC_BITS);
    localparam int TOT  = NSTG + 11;
    localparam int CT_W = 16 + TW;

    localparam logic signed [ACC_W-1:0] T_MAX = 64'sd32767;
    localparam logic signed [ACC_W-1:0] T_MIN = -64'sd32768;
    localparam logic signed [ACC_W-1:0] P_MAX = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] P_MIN = -64'sd2147483648;

    // calibration registers
    logic [23:0] coef_c0_c1_reg;
    logic [39:0] coef_c00_c10_reg;
    logic [31:0] coef_c01_c11_reg;
    logic [31:0] coef_c20_c21_reg;
    logic [15:0] coef_c30_reg;
    logic [2:0]  temp_rate_index_reg;
    logic [2:0]  pressure_rate_index_reg;

    logic signed [11:0] c0, c1;
    logic signed [19:0] c00, c10;
    logic signed [15:0] c01, c11, c20, c21, c30;
    logic signed [ACC_W-1:0] c0_half, c00_one, c10_one, c11_one, c20_one, c21_one;

    logic signed [TW-1:0] t_s;
    logic signed [TW-1:0] p_s;

    logic vld_reg  [TOT];
    logic vld_next [TOT];

    logic signed [TW-1:0]    p_pipe_reg   [1:4];
    logic signed [TW-1:0]    p_pipe_next  [1:4];
    logic signed [ACC_W-1:0] tq_pipe_reg  [1:9];
    logic signed [ACC_W-1:0] tq_pipe_next [1:9];
    logic signed [CT_W-1:0]  ct_pipe_reg  [1:7];
    logic signed [CT_W-1:0]  ct_pipe_next [1:7];
    logic                    clip_pipe_reg  [1:9];
    logic                    clip_pipe_next [1:9];
    logic signed [ACC_W-1:0] e_pipe_reg   [6:8];
    logic signed [ACC_W-1:0] e_pipe_next  [6:8];

    logic signed [ACC_W-1:0] inner1_reg, inner1_next;
    logic signed [ACC_W-1:0] tp_reg, tp_next;
    logic signed [ACC_W-1:0] inner2_reg, inner2_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] pq1_reg, pq1_next;
    logic signed [ACC_W-1:0] pq2_reg, pq2_next;
    logic signed [ACC_W-1:0] pq3_reg, pq3_next;

    logic signed [15:0] temperature_q8_reg, temperature_q8_next;
    logic signed [31:0] pressure_q8_reg, pressure_q8_next;
    logic               saturated_reg, saturated_next;

    logic signed [TW+15:0] c30p;
    logic signed [TW+11:0] c1t;
    sat_val_t s_inner1, s_tq, s_inner2, s_acc, s_pq1, s_pq2, s_pq3;
    sat_val_t mul_a, mul_b, mul_c, mul_d, mul_e;
    logic signed [ACC_W-1:0] t_round, p_round;
    logic t_clip, p_clip;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // register writes; unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_c0_c1_reg          <= '0;
            coef_c00_c10_reg        <= '0;
            coef_c01_c11_reg        <= '0;
            coef_c20_c21_reg        <= '0;
            coef_c30_reg            <= '0;
            temp_rate_index_reg     <= 3'd0;
            pressure_rate_index_reg <= 3'd6;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_C0_C1:     coef_c0_c1_reg          <= cfg_data[23:0];
                CFG_C00_C10:   coef_c00_c10_reg        <= cfg_data;
                CFG_C01_C11:   coef_c01_c11_reg        <= cfg_data[31:0];
                CFG_C20_C21:   coef_c20_c21_reg        <= cfg_data[31:0];
                CFG_C30:       coef_c30_reg            <= cfg_data[15:0];
                CFG_TEMP_RATE: temp_rate_index_reg     <= cfg_data[2:0];
                CFG_PRES_RATE: pressure_rate_index_reg <= cfg_data[2:0];
                default:       ;
            endcase
        end
    end

    // unpack and sign-extend the calibration words
    always_comb
    begin
        c0  = $signed(coef_c0_c1_reg[23:12]);
        c1  = $signed(coef_c0_c1_reg[11:0]);
        c00 = $signed(coef_c00_c10_reg[39:20]);
        c10 = $signed(coef_c00_c10_reg[19:0]);
        c01 = $signed(coef_c01_c11_reg[31:16]);
        c11 = $signed(coef_c01_c11_reg[15:0]);
        c20 = $signed(coef_c20_c21_reg[31:16]);
        c21 = $signed(coef_c20_c21_reg[15:0]);
        c30 = $signed(coef_c30_reg);
        c0_half = ACC_W'(c0)  <<< (FRAC_BITS - 1);
        c00_one = ACC_W'(c00) <<< FRAC_BITS;
        c10_one = ACC_W'(c10) <<< FRAC_BITS;
        c11_one = ACC_W'(c11) <<< FRAC_BITS;
        c20_one = ACC_W'(c20) <<< FRAC_BITS;
        c21_one = ACC_W'(c21) <<< FRAC_BITS;
    end

    // scale both raw words
    bpc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_t
    (
        .clk    (clk),
        .raw    (temp_raw),
        .idx    (temp_rate_index_reg),
        .scaled (t_s)
    );

    bpc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_p
    (
        .clk    (clk),
        .raw    (pressure_raw),
        .idx    (pressure_rate_index_reg),
        .scaled (p_s)
    );

    // fixed-point products, each with registered partial products and a registered result
    bpc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_tp
    (
        .clk (clk),
        .a   (ACC_W'(t_s)),
        .b   (ACC_W'(p_s)),
        .res (mul_a)
    );

    bpc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_pc21
    (
        .clk (clk),
        .a   (ACC_W'(p_s)),
        .b   (c21_one),
        .res (mul_b)
    );

    bpc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_pin
    (
        .clk (clk),
        .a   (ACC_W'(p_pipe_reg[1])),
        .b   (inner1_reg),
        .res (mul_c)
    );

    bpc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_tpin
    (
        .clk (clk),
        .a   (tp_reg),
        .b   (inner2_reg),
        .res (mul_e)
    );

    bpc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_pacc
    (
        .clk (clk),
        .a   (ACC_W'(p_pipe_reg[4])),
        .b   (acc_reg),
        .res (mul_d)
    );

    function automatic logic signed [ACC_W-1:0] rsh_round(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mg;
        logic [ACC_W-1:0] r;
        mg = v[ACC_W-1] ? (64'd0 - v) : v;
        r  = (mg + (64'd1 << (FRAC_BITS - 9))) >> (FRAC_BITS - 8);
        return v[ACC_W-1] ? -$signed(r) : $signed(r);
    endfunction

    // polynomial stages
    always_comb
    begin
        // stage 1: first coefficient terms and the temperature sum
        c30p     = c30 * p_s;
        c1t      = c1 * t_s;
        s_inner1 = sat_add64(c20_one, ACC_W'(c30p));
        s_tq     = sat_add64(c0_half, ACC_W'(c1t));
        inner1_next       = s_inner1.value;
        tq_pipe_next[1]   = s_tq.value;
        ct_pipe_next[1]   = c01 * t_s;
        p_pipe_next[1]    = p_s;
        clip_pipe_next[1] = s_inner1.clip | s_tq.clip;

        // stage 3: T*P and the cross-term inner sum
        s_inner2    = sat_add64(c11_one, mul_b.value);
        tp_next     = mul_a.value;
        inner2_next = s_inner2.value;

        // stage 4: linear pressure coefficient
        s_acc    = sat_add64(c10_one, mul_c.value);
        acc_next = s_acc.value;

        // stages 7 to 9: accumulate the pressure terms in order
        s_pq1    = sat_add64(c00_one, mul_d.value);
        s_pq2    = sat_add64(pq1_reg, ACC_W'(ct_pipe_reg[7]));
        s_pq3    = sat_add64(pq2_reg, e_pipe_reg[8]);
        pq1_next = s_pq1.value;
        pq2_next = s_pq2.value;
        pq3_next = s_pq3.value;

        // delay lines
        for (int k = 2; k <= 4; k++)
            p_pipe_next[k] = p_pipe_reg[k-1];
        for (int k = 2; k <= 9; k++)
            tq_pipe_next[k] = tq_pipe_reg[k-1];
        for (int k = 2; k <= 7; k++)
            ct_pipe_next[k] = ct_pipe_reg[k-1];
        e_pipe_next[6] = mul_e.value;
        e_pipe_next[7] = e_pipe_reg[6];
        e_pipe_next[8] = e_pipe_reg[7];

        // collect clip events along the pipe
        clip_pipe_next[2] = clip_pipe_reg[1];
        clip_pipe_next[3] = clip_pipe_reg[2] | mul_a.clip | mul_b.clip | s_inner2.clip;
        clip_pipe_next[4] = clip_pipe_reg[3] | mul_c.clip | s_acc.clip;
        clip_pipe_next[5] = clip_pipe_reg[4];
        clip_pipe_next[6] = clip_pipe_reg[5] | mul_e.clip;
        clip_pipe_next[7] = clip_pipe_reg[6] | mul_d.clip | s_pq1.clip;
        clip_pipe_next[8] = clip_pipe_reg[7] | s_pq2.clip;
        clip_pipe_next[9] = clip_pipe_reg[8] | s_pq3.clip;
    end

    // output stage: drop to eight fraction bits and clamp
    always_comb
    begin
        t_round = rsh_round(tq_pipe_reg[9]);
        p_round = rsh_round(pq3_reg);
        t_clip  = 1'b0;
        p_clip  = 1'b0;
        if (t_round > T_MAX)
        begin
            temperature_q8_next = 16'sh7fff;
            t_clip              = 1'b1;
        end
        else if (t_round < T_MIN)
        begin
            temperature_q8_next = 16'sh8000;
            t_clip              = 1'b1;
        end
        else
        begin
            temperature_q8_next = t_round[15:0];
        end
        if (p_round > P_MAX)
        begin
            pressure_q8_next = 32'sh7fffffff;
            p_clip           = 1'b1;
        end
        else if (p_round < P_MIN)
        begin
            pressure_q8_next = 32'sh80000000;
            p_clip           = 1'b1;
        end
        else
        begin
            pressure_q8_next = p_round[31:0];
        end
        saturated_next = clip_pipe_reg[9] | t_clip | p_clip;
    end

    // shift the valid line along, entering each request at its head
    always_comb
    begin
        vld_next[0] = start && !busy;
        for (int k = 1; k < TOT; k++)
            vld_next[k] = vld_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_pipe_reg          <= p_pipe_next;
        tq_pipe_reg         <= tq_pipe_next;
        ct_pipe_reg         <= ct_pipe_next;
        clip_pipe_reg       <= clip_pipe_next;
        e_pipe_reg          <= e_pipe_next;
        inner1_reg          <= inner1_next;
        tp_reg              <= tp_next;
        inner2_reg          <= inner2_next;
        acc_reg             <= acc_next;
        pq1_reg             <= pq1_next;
        pq2_reg             <= pq2_next;
        pq3_reg             <= pq3_next;
        temperature_q8_reg  <= temperature_q8_next;
        pressure_q8_reg     <= pressure_q8_next;
        saturated_reg       <= saturated_next;
    end

    assign done           = vld_reg[TOT-1];
    assign temperature_q8 = temperature_q8_reg;
    assign pressure_q8    = pressure_q8_reg;
    assign saturated      = saturated_reg;

    // a result follows its request after the fixed pipeline depth
    `BPC_ASSERT_NOW(a_done_latency, done, $past(start, TOT), "result without a matching request")
    // a clip seen inside the pipe must reach the flag
    `BPC_ASSERT_NEXT(a_clip_reaches_flag, vld_reg[NSTG+9] && clip_pipe_reg[9], done && saturated, "internal clip lost before the output")

endmodule
